### src/lz77te_pkg.sv
// lz77te_pkg: shared types and codes for the lz77 tuple encoder
// no dependencies
`default_nettype none
package lz77te_pkg;

    typedef enum logic [1:0]
    {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_DRAIN = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CAND,
        ST_RD,
        ST_CMP,
        ST_CHK,
        ST_SYM,
        ST_SYMW,
        ST_OUT
    } state_t;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage
`default_nettype wire

### src/lz77_tuple_encoder.sv
// lz77_tuple_encoder: history ring memory and candidate search sequencer
// depends on lz77te_pkg
// a tuple drain compares up to WINDOW candidates byte by byte, each until a mismatch
// or the lookahead or overlap limit, then reads the next symbol; a drain that finds
// nothing ready answers without a search
// throughput: one word at a time, input waits until the output word is taken
// reset: async active low clears counters, end flag and the state machine;
// ring contents are undefined until written
`default_nettype none
module lz77_tuple_encoder
    import lz77te_pkg::*;
#(
    parameter int WINDOW     = 1024,
    parameter int LOOKAHEAD  = 100,
    parameter int RING_DEPTH = 2048
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte[7:0]
    input  wire  [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // distance[10:0], match_length[17:11], next_symbol[25:18],
                                   // zero[31:26]
    output logic        m_tuser,   // nothing_ready[0]
    output logic        m_tlast    // final_tuple
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [COUNT_W-1:0] WIN = COUNT_W'(WINDOW);
    localparam logic [COUNT_W-1:0] LA  = COUNT_W'(LOOKAHEAD);
    localparam logic [COUNT_W:0]   RD  = (COUNT_W+1)'(RING_DEPTH);

    logic [7:0] ring [RING_DEPTH];
    logic [7:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic ren;

    state_t state_reg, state_next;
    logic [COUNT_W-1:0] recv_reg, pos_reg, end_reg, dist_reg, n_reg;
    logic [COUNT_W-1:0] best_len_reg, best_dist_reg;
    logic [7:0] cur_reg;
    logic ended_reg;
    logic [31:0] out_data_reg;
    logic out_user_reg, out_last_reg, out_valid_reg;

    logic [COUNT_W-1:0] held, src_pos, cur_pos, nxt;
    logic [COUNT_W:0] end_sum, nxt_sum;
    logic acc_in, acc_out, can_store, have, more_cand, cmp_go;

    assign held     = recv_reg - pos_reg;
    assign acc_in   = s_tvalid && s_tready;
    assign acc_out  = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign can_store = !ended_reg && (recv_reg != COUNT_MAX)
                       && ({1'b0, held} + (COUNT_W+1)'(WINDOW) < RD);
    assign have     = (held > LA) || (ended_reg && held != '0);
    assign src_pos  = pos_reg - dist_reg + n_reg;
    assign cur_pos  = pos_reg + n_reg;
    assign more_cand = (dist_reg < WIN) && (dist_reg < pos_reg);
    assign cmp_go   = (cur_pos < end_reg) && (src_pos < pos_reg);
    assign end_sum  = {1'b0, pos_reg} + {1'b0, LA};
    assign nxt_sum  = {1'b0, pos_reg} + {1'b0, best_len_reg} + (COUNT_W+1)'(1);
    assign nxt      = (nxt_sum > {1'b0, recv_reg}) ? recv_reg : nxt_sum[COUNT_W-1:0];

    // ring: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (acc_in && kind_t'(s_tuser) == KIND_DATA && can_store)
            ring[recv_reg[AW-1:0]] <= s_tdata;
        if (ren)
            rdata_reg <= ring[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (acc_in && kind_t'(s_tuser) == KIND_DRAIN)
                         state_next = have ? ST_CAND : ST_OUT;
            ST_CAND: state_next = (more_cand || dist_reg == '0) ? ST_RD : ST_SYM;
            ST_RD:   state_next = cmp_go ? ST_CMP : ST_CAND;
            ST_CMP:  state_next = ST_CHK;
            ST_CHK:  state_next = (rdata_reg == cur_reg) ? ST_RD : ST_CAND;
            ST_SYM:  state_next = ST_SYMW;
            ST_SYMW: state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // read address per state
    always_comb
    begin
        ren = 1'b0;
        raddr = '0;
        unique case (state_reg)
            ST_CAND: begin ren = 1'b1; raddr = pos_reg[AW-1:0]; end
            ST_RD:   begin ren = 1'b1; raddr = cur_pos[AW-1:0]; end
            ST_CMP:  begin ren = 1'b1; raddr = src_pos[AW-1:0]; end
            ST_SYM:
            begin
                ren = 1'b1;
                if (best_len_reg == '0)
                    raddr = pos_reg[AW-1:0];
                else if (pos_reg + best_len_reg >= recv_reg)
                    raddr = AW'(pos_reg + best_len_reg - 1'b1);
                else
                    raddr = AW'(pos_reg + best_len_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            recv_reg <= '0;
            pos_reg <= '0;
            ended_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc_out)
                out_valid_reg <= 1'b0;
            if (acc_in && kind_t'(s_tuser) == KIND_DATA && can_store)
                recv_reg <= recv_reg + 1'b1;
            if (acc_in && kind_t'(s_tuser) == KIND_END)
                ended_reg <= 1'b1;
            if (state_reg == ST_SYMW)
                pos_reg <= nxt;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    // search datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                dist_reg <= '0;
                n_reg <= '0;
                best_len_reg <= '0;
                best_dist_reg <= '0;
                end_reg <= (end_sum > {1'b0, recv_reg}) ? recv_reg : end_sum[COUNT_W-1:0];
                if (!out_valid_reg)
                begin
                    out_data_reg <= '0;
                    out_user_reg <= 1'b1;
                    out_last_reg <= 1'b0;
                end
            end
            ST_CAND:
            begin
                dist_reg <= dist_reg + 1'b1;
                n_reg <= '0;
            end
            ST_RD:
            begin
                if (!cmp_go && n_reg > best_len_reg && dist_reg != '0)
                begin
                    best_len_reg <= n_reg;
                    best_dist_reg <= dist_reg;
                end
            end
            ST_CMP:
            begin
                cur_reg <= rdata_reg;
            end
            ST_CHK:
            begin
                // src byte is back, cur byte was captured in CMP
                if (rdata_reg == cur_reg)
                    n_reg <= n_reg + 1'b1;
                else if (n_reg > best_len_reg)
                begin
                    best_len_reg <= n_reg;
                    best_dist_reg <= dist_reg;
                end
            end
            ST_SYMW:
            begin
                out_data_reg <= {6'd0, rdata_reg, best_len_reg[6:0], best_dist_reg[10:0]};
                out_user_reg <= 1'b0;
                out_last_reg <= ended_reg && (nxt >= recv_reg);
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### tb/lz77_tuple_checker.sv
// lz77_tuple_checker: watches both stream channels of the lz77 tuple encoder,
// predicts each tuple from the accepted input words and compares field by field
// depends on lz77te_pkg
`default_nettype none
module lz77_tuple_checker
    import lz77te_pkg::*;
#(
    parameter int WINDOW     = 1024,
    parameter int LOOKAHEAD  = 100,
    parameter int RING_DEPTH = 2048
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte[7:0]
    input  wire  [1:0]  s_tuser,   // kind[1:0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,   // distance[10:0], match_length[17:11], next_symbol[25:18],
                                   // zero[31:26]
    input  wire         m_tuser,   // nothing_ready[0]
    input  wire         m_tlast,   // final_tuple
    output int          errors,
    output int          pending,
    output logic        all_encoded
);

    localparam int QD = 16;

    typedef struct packed
    {
        logic [10:0] distance;
        logic [6:0]  match_length;
        logic [7:0]  next_symbol;
        logic        final_tuple;
        logic        nothing_ready;
    } tuple_t;

    logic [7:0] history [RING_DEPTH];
    int unsigned received;
    int unsigned position;
    logic        ended;
    tuple_t      exp_mem [QD];
    int unsigned wr_cnt;
    int unsigned rd_cnt;

    initial
    begin
        errors = 0;
        received = 0;
        position = 0;
        ended = 1'b0;
        wr_cnt = 0;
        rd_cnt = 0;
        foreach (history[i]) history[i] = 8'h00;
    end

    assign pending = int'(wr_cnt - rd_cnt);
    assign all_encoded = ended && position >= received;

    function automatic logic [7:0] hist_at(int unsigned p);
        return history[p % RING_DEPTH];
    endfunction

    // encode the current position and advance it; flag nothing_ready when too few bytes are held
    function automatic tuple_t encode_tuple();
        tuple_t      t;
        int unsigned held;
        int unsigned stop;
        int unsigned best_len;
        int unsigned best_dist;
        int unsigned n;
        int unsigned last;
        int unsigned nxt;
        logic [7:0]  sym;
        t = '0;
        held = received - position;
        if (!(held > LOOKAHEAD || (ended && held > 0)))
        begin
            t.nothing_ready = 1'b1;
            return t;
        end
        stop = position + LOOKAHEAD;
        if (stop > received)
            stop = received;
        best_len = 0;
        best_dist = 0;
        sym = hist_at(position);
        for (int unsigned d = 1; d <= WINDOW && d <= position; d++)
        begin
            n = 0;
            while (position + n < stop && position - d + n < position &&
                   hist_at(position - d + n) == hist_at(position + n))
                n++;
            if (n > best_len)
            begin
                last = position + n - 1;
                best_len = n;
                best_dist = d;
                sym = hist_at(last + 1 >= received ? last : last + 1);
            end
        end
        nxt = position + best_len + 1;
        if (nxt > received)
            nxt = received;
        position = nxt;
        t.distance = best_dist[10:0];
        t.match_length = best_len[6:0];
        t.next_symbol = sym;
        t.final_tuple = ended && nxt >= received;
        return t;
    endfunction

    always @(posedge clk)
    begin
        tuple_t exp_t;
        tuple_t got_t;
        if (rst_n && s_tvalid && s_tready)
        begin
            case (kind_t'(s_tuser))
                KIND_DATA:
                    if (!ended && received < COUNT_MAX &&
                        (received - position) + WINDOW < RING_DEPTH)
                    begin
                        history[received % RING_DEPTH] = s_tdata;
                        received++;
                    end
                KIND_END:   ended = 1'b1;
                KIND_DRAIN:
                begin
                    exp_mem[wr_cnt % QD] = encode_tuple();
                    wr_cnt++;
                end
                default: ;
            endcase
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got_t = {m_tdata[10:0], m_tdata[17:11], m_tdata[25:18], m_tlast, m_tuser};
            if (wr_cnt == rd_cnt)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected tuple %h", got_t);
            end
            else
            begin
                exp_t = exp_mem[rd_cnt % QD];
                rd_cnt++;
                if (got_t !== exp_t)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d %0d %h %b %b got %0d %0d %h %b %b",
                                 exp_t.distance, exp_t.match_length, exp_t.next_symbol,
                                 exp_t.final_tuple, exp_t.nothing_ready,
                                 got_t.distance, got_t.match_length, got_t.next_symbol,
                                 got_t.final_tuple, got_t.nothing_ready);
                end
            end
        end
    end

endmodule
`default_nettype wire

### tb/tb.sv
// tb: stimulus and verdict for the lz77 tuple encoder
// depends on lz77te_pkg, lz77_tuple_encoder and lz77_tuple_checker
`default_nettype none
module tb;
    import lz77te_pkg::*;

    localparam int IDLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [1:0]  s_tuser = KIND_DATA;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    logic        all_encoded;
    logic [7:0]  stall_pat = 8'hFF;
    int          burst_left = 0;
    int          idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lz77_tuple_encoder dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    lz77_tuple_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .errors(errors), .pending(pending), .all_encoded(all_encoded)
    );

    // receiver stall pattern, reloaded now and then
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= stall_pat[0];
            if ($urandom_range(0, 31) == 0)
                stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
            else
                stall_pat <= {stall_pat[0], stall_pat[7:1]};
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[lz77_tuple_encoder] ERROR");
            $finish;
        end
    end

    task automatic send_word(kind_t kind, logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 8)
            return 8'h41 + 8'($urandom_range(0, 3));
        return 8'($urandom);
    endfunction

    initial
    begin
        logic [7:0] rb;
        int         run;
        int         sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty drain, unused kind, extreme bytes, short lookahead
        send_word(KIND_DRAIN, 8'h00);
        send_word(KIND_NONE, 8'hFF);
        send_word(KIND_DATA, 8'h00);
        send_word(KIND_DATA, 8'hFF);
        send_word(KIND_DATA, 8'hAA);
        send_word(KIND_DATA, 8'h55);
        send_word(KIND_DRAIN, 8'hFF);
        for (int i = 0; i < 8; i++)
            send_word(KIND_DATA, 8'h41);
        send_word(KIND_DRAIN, 8'h00);

        // random: mostly small-alphabet data with repeats, interleaved drains
        for (int i = 0; i < 460; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
                send_word(KIND_NONE, 8'($urandom));
            else if (sel < 30)
                send_word(KIND_DRAIN, 8'($urandom));
            else if (sel < 34)
            begin
                rb = pick_byte();
                run = $urandom_range(3, 20);
                for (int j = 0; j < run; j++)
                    send_word(KIND_DATA, rb);
                i += run - 1;
            end
            else
                send_word(KIND_DATA, pick_byte());
        end

        // end of block, drain everything, then words after the end
        send_word(KIND_END, 8'($urandom));
        while (!all_encoded)
            send_word(KIND_DRAIN, 8'($urandom));
        send_word(KIND_DRAIN, 8'h00);
        send_word(KIND_DATA, 8'h5A);
        send_word(KIND_END, 8'h00);
        send_word(KIND_DRAIN, 8'hFF);
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("[lz77_tuple_encoder] OK");
        else
            $display("[lz77_tuple_encoder] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
